// File: hw/rtl/lcd_pkg.sv
// shared types and constants of the line clip and dot count block
`timescale 1ns / 1ps
`default_nettype none

package lcd_pkg;

    // fixed point formats
    localparam int PIX_FRAC = 4;
    localparam int IN_FRAC  = 16;
    localparam int GUARD    = 8;
    localparam int TBITS    = 22;

    localparam int CFG_W  = 16;
    localparam int IN_W   = 24;
    localparam int T_W    = TBITS + 1;
    localparam int POS_W  = 42;
    localparam int MAG_W  = 41;
    localparam int DIV_W  = 42;
    localparam int PROD_W = MAG_W + T_W;
    localparam int RND_W  = PROD_W - TBITS;
    localparam int V_W    = POS_W + 1;
    localparam int CLP_W  = CFG_W + IN_FRAC;
    localparam int GD_W   = CLP_W - (IN_FRAC - GUARD);
    localparam int SQ_W   = 2 * GD_W;
    localparam int D2_W   = SQ_W + 1;
    localparam int DOT_SH   = 2 * (PIX_FRAC + GUARD);
    localparam int SOLID_SH = DOT_SH - 4;
    localparam int DSH_W  = D2_W - SOLID_SH;
    localparam int CNT_W  = 13;
    localparam int CSQ_W  = 2 * CNT_W;
    localparam int KP_W   = 32;
    localparam int DOT_K   = 25;
    localparam int SOLID_K = 9;

    localparam logic [T_W-1:0]   TONE     = T_W'(1) << TBITS;
    localparam logic [CNT_W-1:0] MAX_CAND = '1;

    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_AREA_LEFT,
        REG_AREA_TOP,
        REG_AREA_WIDTH,
        REG_AREA_HEIGHT,
        REG_BOUND_LEFT,
        REG_BOUND_TOP,
        REG_BOUND_RIGHT,
        REG_BOUND_BOTTOM
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] area_left;
        logic [CFG_W-1:0] area_top;
        logic [CFG_W-1:0] area_width;
        logic [CFG_W-1:0] area_height;
        logic [CFG_W-1:0] bound_left;
        logic [CFG_W-1:0] bound_top;
        logic [CFG_W-1:0] bound_right;
        logic [CFG_W-1:0] bound_bottom;
    } t_cfg;

    typedef struct packed {
        logic signed [IN_W-1:0] from_x;
        logic signed [IN_W-1:0] from_y;
        logic signed [IN_W-1:0] to_x;
        logic signed [IN_W-1:0] to_y;
        logic                   dotted;
    } t_seg;

    // one clip edge: division request or fixed parameter
    typedef struct packed {
        logic             act;
        logic             ent;
        logic             eq;
        logic [DIV_W-1:0] n;
        logic [DIV_W-1:0] m;
    } t_edge;

    // segment geometry carried along the pipe
    typedef struct packed {
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic [MAG_W-1:0]        adx;
        logic [MAG_W-1:0]        ady;
        logic                    nx;
        logic                    ny;
        logic                    dotted;
        logic                    rej;
    } t_geom;

    typedef struct packed {
        t_geom       g;
        t_edge [3:0] edg;
    } t_map_out;

    typedef struct packed {
        t_geom          g;
        logic [T_W-1:0] t_in;
        logic [T_W-1:0] t_out;
    } t_clip_out;

    typedef struct packed {
        logic                  rej;
        logic                  dotted;
        logic [3:0][CFG_W-1:0] pix;
        logic [DSH_W-1:0]      dsh;
    } t_span_out;

endpackage

`default_nettype wire

// File: hw/rtl/lcd_if.sv
// segment and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface lcd_seg_if;
    import lcd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] from_x;
    logic signed [IN_W-1:0] from_y;
    logic signed [IN_W-1:0] to_x;
    logic signed [IN_W-1:0] to_y;
    logic                   dotted;
    modport source (output valid, from_x, from_y, to_x, to_y, dotted, input ready);
    modport sink   (input valid, from_x, from_y, to_x, to_y, dotted, output ready);
endinterface

interface lcd_res_if;
    import lcd_pkg::*;
    logic             valid;
    logic             ready;
    logic             visible;
    logic [CFG_W-1:0] start_x;
    logic [CFG_W-1:0] start_y;
    logic [CFG_W-1:0] end_x;
    logic [CFG_W-1:0] end_y;
    logic [CNT_W-1:0] dot_count;
    modport source (output valid, visible, start_x, start_y, end_x, end_y, dot_count,
                    input ready);
    modport sink   (input valid, visible, start_x, start_y, end_x, end_y, dot_count,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/line_clip_and_dot_count.sv
// top level of the line clip and dot count pipeline
// pipeline stages: 3 mapping/setup, 23 division and combine for the clip edges,
//   7 endpoint and length, 14 count; every stage has its own valid and fills bubbles
// throughput: one segment per cycle while the result side takes beats
// back-pressure: a stall holds only the unbroken run of full stages behind the result
// reset: synchronous active low, empties the pipe and loads the register reset values
`timescale 1ns / 1ps
`default_nettype none

module line_clip_and_dot_count (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lcd_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [lcd_pkg::CFG_W-1:0]     i_cfg_data,
    lcd_seg_if.sink                       i_seg,
    lcd_res_if.source                     o_res
);
    import lcd_pkg::*;

    t_cfg      r_cfg;
    t_seg      w_seg;
    t_map_out  w_map;
    t_clip_out w_clip;
    t_span_out w_span;
    logic      w_map_v, w_clip_v, w_span_v;
    logic      w_clip_rdy, w_span_rdy, w_cnt_rdy;

    // configuration registers: user must write only while pipe is idle; not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.area_left    <= '0;
            r_cfg.area_top     <= '0;
            r_cfg.area_width   <= CFG_W'(2048);
            r_cfg.area_height  <= CFG_W'(2048);
            r_cfg.bound_left   <= '0;
            r_cfg.bound_top    <= '0;
            r_cfg.bound_right  <= CFG_W'(2048);
            r_cfg.bound_bottom <= CFG_W'(2048);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_AREA_LEFT:    r_cfg.area_left    <= i_cfg_data;
                REG_AREA_TOP:     r_cfg.area_top     <= i_cfg_data;
                REG_AREA_WIDTH:   r_cfg.area_width   <= i_cfg_data;
                REG_AREA_HEIGHT:  r_cfg.area_height  <= i_cfg_data;
                REG_BOUND_LEFT:   r_cfg.bound_left   <= i_cfg_data;
                REG_BOUND_TOP:    r_cfg.bound_top    <= i_cfg_data;
                REG_BOUND_RIGHT:  r_cfg.bound_right  <= i_cfg_data;
                REG_BOUND_BOTTOM: r_cfg.bound_bottom <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // segment beat payload
    assign w_seg.from_x = i_seg.from_x;
    assign w_seg.from_y = i_seg.from_y;
    assign w_seg.to_x   = i_seg.to_x;
    assign w_seg.to_y   = i_seg.to_y;
    assign w_seg.dotted = i_seg.dotted;

    // map fractions into pixel space and classify the four clip edges
    lcd_map u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_seg.valid),
        .i_seg       (w_seg),
        .o_ready     (i_seg.ready),
        .o_valid     (w_map_v),
        .o_data      (w_map),
        .i_nxt_ready (w_clip_rdy)
    );

    // one quotient bit per stage, all edges side by side
    lcd_clip u_clip (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_map_v),
        .i_data      (w_map),
        .o_ready     (w_clip_rdy),
        .o_valid     (w_clip_v),
        .o_data      (w_clip),
        .i_nxt_ready (w_span_rdy)
    );

    // clipped endpoints and squared length
    lcd_span u_span (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_clip_v),
        .i_data      (w_clip),
        .o_ready     (w_span_rdy),
        .o_valid     (w_span_v),
        .o_data      (w_span),
        .i_nxt_ready (w_cnt_rdy)
    );

    // dot count search and result register
    lcd_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_span_v),
        .i_data  (w_span),
        .o_ready (w_cnt_rdy),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// File: hw/rtl/lcd_map.sv
// area mapping and clip edge setup, three stages
`timescale 1ns / 1ps
`default_nettype none

module lcd_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcd_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  lcd_pkg::t_seg     i_seg,
    output logic              o_ready,
    output logic              o_valid,
    output lcd_pkg::t_map_out o_data,
    input  logic              i_nxt_ready
);
    import lcd_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] fxw;
        logic signed [POS_W-1:0] fyh;
        logic signed [POS_W-1:0] dx;
        logic signed [POS_W-1:0] dy;
        logic                    dotted;
    } t_m0;

    typedef struct packed {
        logic signed [POS_W-1:0]       sx;
        logic signed [POS_W-1:0]       sy;
        logic signed [POS_W-1:0]       dx;
        logic signed [POS_W-1:0]       dy;
        logic [3:0][POS_W-1:0]         q;
        logic                          dotted;
    } t_m1;

    logic [2:0] r_v;
    logic [2:0] w_en;
    t_m0        r_m0, n_m0;
    t_m1        r_m1, n_m1;
    t_map_out   r_m2, n_m2;

    always_comb begin
        w_en[2] = !r_v[2] | i_nxt_ready;
        w_en[1] = !r_v[1] | w_en[2];
        w_en[0] = !r_v[0] | w_en[1];
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[2];
    assign o_data  = r_m2;

    // stage 0: fraction times area size
    always_comb begin
        logic signed [IN_W:0] w_dfx;
        logic signed [IN_W:0] w_dfy;
        w_dfx = (IN_W+1)'(i_seg.to_x) - (IN_W+1)'(i_seg.from_x);
        w_dfy = (IN_W+1)'(i_seg.to_y) - (IN_W+1)'(i_seg.from_y);
        n_m0.fxw = POS_W'(i_seg.from_x) * $signed(POS_W'(i_cfg.area_width));
        n_m0.fyh = POS_W'(i_seg.from_y) * $signed(POS_W'(i_cfg.area_height));
        n_m0.dx  = POS_W'(w_dfx) * $signed(POS_W'(i_cfg.area_width));
        n_m0.dy  = POS_W'(w_dfy) * $signed(POS_W'(i_cfg.area_height));
        n_m0.dotted = i_seg.dotted;
    end

    // stage 1: origin offset and edge distances
    always_comb begin
        logic signed [CFG_W:0] w_dl, w_dr, w_dt, w_db;
        w_dl = $signed({1'b0, i_cfg.area_left})    - $signed({1'b0, i_cfg.bound_left});
        w_dr = $signed({1'b0, i_cfg.bound_right})  - $signed({1'b0, i_cfg.area_left});
        w_dt = $signed({1'b0, i_cfg.area_top})     - $signed({1'b0, i_cfg.bound_top});
        w_db = $signed({1'b0, i_cfg.bound_bottom}) - $signed({1'b0, i_cfg.area_top});
        n_m1.sx = r_m0.fxw + $signed(POS_W'({i_cfg.area_left, {IN_FRAC{1'b0}}}));
        n_m1.sy = r_m0.fyh + $signed(POS_W'({i_cfg.area_top, {IN_FRAC{1'b0}}}));
        n_m1.dx = r_m0.dx;
        n_m1.dy = r_m0.dy;
        n_m1.q[0] = (POS_W'(w_dl) <<< IN_FRAC) + r_m0.fxw;
        n_m1.q[1] = (POS_W'(w_dr) <<< IN_FRAC) - r_m0.fxw;
        n_m1.q[2] = (POS_W'(w_dt) <<< IN_FRAC) + r_m0.fyh;
        n_m1.q[3] = (POS_W'(w_db) <<< IN_FRAC) - r_m0.fyh;
        n_m1.dotted = r_m0.dotted;
    end

    // stage 2: classify each edge
    always_comb begin
        logic signed [POS_W-1:0] w_p [4];
        logic signed [POS_W-1:0] w_q;
        logic                    w_rej;
        w_p[0] = -r_m1.dx;
        w_p[1] = r_m1.dx;
        w_p[2] = -r_m1.dy;
        w_p[3] = r_m1.dy;
        w_rej = (i_cfg.bound_right <= i_cfg.bound_left) ||
                (i_cfg.bound_bottom <= i_cfg.bound_top);
        for (int e = 0; e < 4; e++) begin
            w_q = $signed(r_m1.q[e]);
            n_m2.edg[e].act = 1'b0;
            n_m2.edg[e].ent = w_p[e][POS_W-1];
            n_m2.edg[e].eq  = 1'b0;
            n_m2.edg[e].n   = '0;
            n_m2.edg[e].m   = DIV_W'(1);
            if (w_p[e] == '0) begin
                if (w_q < 0) w_rej = 1'b1;
            end else if (w_p[e] < 0) begin
                // entry edge
                if (w_q < 0) begin
                    if (w_q < w_p[e]) begin
                        w_rej = 1'b1;
                    end else if (w_q == w_p[e]) begin
                        n_m2.edg[e].eq = 1'b1;
                    end else begin
                        n_m2.edg[e].act = 1'b1;
                        n_m2.edg[e].n   = DIV_W'(-w_q);
                        n_m2.edg[e].m   = DIV_W'(-w_p[e]);
                    end
                end
            end else begin
                // exit edge
                if (w_q < 0) begin
                    w_rej = 1'b1;
                end else if (w_q < w_p[e]) begin
                    n_m2.edg[e].act = 1'b1;
                    n_m2.edg[e].n   = DIV_W'(w_q);
                    n_m2.edg[e].m   = DIV_W'(w_p[e]);
                end
            end
        end
        n_m2.g.sx  = r_m1.sx;
        n_m2.g.sy  = r_m1.sy;
        n_m2.g.nx  = r_m1.dx[POS_W-1];
        n_m2.g.ny  = r_m1.dy[POS_W-1];
        n_m2.g.adx = r_m1.dx[POS_W-1] ? MAG_W'(-r_m1.dx) : MAG_W'(r_m1.dx);
        n_m2.g.ady = r_m1.dy[POS_W-1] ? MAG_W'(-r_m1.dy) : MAG_W'(r_m1.dy);
        n_m2.g.dotted = r_m1.dotted;
        n_m2.g.rej = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_m0 <= n_m0;
        if (w_en[1]) r_m1 <= n_m1;
        if (w_en[2]) r_m2 <= n_m2;
    end

endmodule

`default_nettype wire

// File: hw/rtl/lcd_clip.sv
// pipelined restoring dividers, one per clip edge, and entry/exit combine
`timescale 1ns / 1ps
`default_nettype none

module lcd_clip (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  lcd_pkg::t_map_out  i_data,
    output logic               o_ready,
    output logic               o_valid,
    output lcd_pkg::t_clip_out o_data,
    input  logic               i_nxt_ready
);
    import lcd_pkg::*;

    localparam int NS = TBITS + 1;

    typedef struct packed {
        t_geom                  g;
        logic [3:0]             act;
        logic [3:0]             ent;
        logic [3:0]             eq;
        logic [3:0][DIV_W-1:0]  rem;
        logic [3:0][DIV_W-1:0]  den;
        logic [3:0][TBITS-1:0]  quo;
    } t_dstage;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;
    t_dstage       r_d [TBITS];
    t_dstage       n_d [TBITS];
    t_dstage       w_ld;
    t_clip_out     r_o, n_o;

    // one quotient bit per edge
    function automatic t_dstage div_step(t_dstage s);
        t_dstage          o;
        logic [DIV_W-1:0] sh;
        o = s;
        for (int e = 0; e < 4; e++) begin
            sh = {s.rem[e][DIV_W-2:0], 1'b0};
            if (sh >= s.den[e]) begin
                o.rem[e] = sh - s.den[e];
                o.quo[e] = {s.quo[e][TBITS-2:0], 1'b1};
            end else begin
                o.rem[e] = sh;
                o.quo[e] = {s.quo[e][TBITS-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] | i_nxt_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] | w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NS-1];
    assign o_data  = r_o;

    always_comb begin
        w_ld.g = i_data.g;
        for (int e = 0; e < 4; e++) begin
            w_ld.act[e] = i_data.edg[e].act;
            w_ld.ent[e] = i_data.edg[e].ent;
            w_ld.eq[e]  = i_data.edg[e].eq;
            w_ld.rem[e] = i_data.edg[e].n;
            w_ld.den[e] = i_data.edg[e].m;
            w_ld.quo[e] = '0;
        end
        n_d[0] = div_step(w_ld);
        for (int k = 1; k < TBITS; k++) begin
            n_d[k] = div_step(r_d[k-1]);
        end
    end

    // entry rounds up, exit rounds down; keep latest entry and earliest exit
    always_comb begin
        logic [T_W-1:0] w_t;
        logic [T_W-1:0] w_first;
        logic [T_W-1:0] w_last;
        w_first = '0;
        w_last  = TONE;
        for (int e = 0; e < 4; e++) begin
            if (r_d[TBITS-1].act[e]) begin
                w_t = T_W'(r_d[TBITS-1].quo[e]) +
                      T_W'(r_d[TBITS-1].ent[e] && (r_d[TBITS-1].rem[e] != '0));
            end else if (r_d[TBITS-1].ent[e]) begin
                w_t = r_d[TBITS-1].eq[e] ? TONE : '0;
            end else begin
                w_t = TONE;
            end
            if (r_d[TBITS-1].ent[e]) begin
                if (w_t > w_first) w_first = w_t;
            end else begin
                if (w_t < w_last) w_last = w_t;
            end
        end
        n_o.g     = r_d[TBITS-1].g;
        n_o.g.rej = r_d[TBITS-1].g.rej | (w_first > w_last);
        n_o.t_in  = w_first;
        n_o.t_out = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TBITS; k++) begin
            if (w_en[k]) r_d[k] <= n_d[k];
        end
        if (w_en[NS-1]) r_o <= n_o;
    end

endmodule

`default_nettype wire

// File: hw/rtl/lcd_span.sv
// clipped endpoints, clamp, pixel rounding and squared length
`timescale 1ns / 1ps
`default_nettype none

module lcd_span (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcd_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  lcd_pkg::t_clip_out i_data,
    output logic               o_ready,
    output logic               o_valid,
    output lcd_pkg::t_span_out o_data,
    input  logic               i_nxt_ready
);
    import lcd_pkg::*;

    localparam int NS = 7;
    localparam logic [PROD_W-1:0] HALF_T  = PROD_W'(1) << (TBITS - 1);
    localparam logic [CLP_W:0]    HALF_PX = (CLP_W+1)'(1) << (IN_FRAC - 1);

    typedef struct packed {
        logic                    rej;
        logic                    dotted;
        logic                    nx;
        logic                    ny;
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic [3:0][PROD_W-1:0]  prod;
    } t_s0;

    typedef struct packed {
        logic                    rej;
        logic                    dotted;
        logic                    nx;
        logic                    ny;
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic [3:0][RND_W-1:0]   rnd;
    } t_s1;

    typedef struct packed {
        logic                rej;
        logic                dotted;
        logic [3:0][V_W-1:0] v;
    } t_s2;

    typedef struct packed {
        logic                  rej;
        logic                  dotted;
        logic [3:0][CLP_W-1:0] c;
    } t_s3;

    typedef struct packed {
        logic                  rej;
        logic                  dotted;
        logic [3:0][CFG_W-1:0] pix;
        logic [1:0][GD_W:0]    gd;
    } t_s4;

    typedef struct packed {
        logic                  rej;
        logic                  dotted;
        logic [3:0][CFG_W-1:0] pix;
        logic [1:0][SQ_W-1:0]  sq;
    } t_s5;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;
    t_s0 r_s0, n_s0;
    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    t_span_out r_s6, n_s6;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] | i_nxt_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] | w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NS-1];
    assign o_data  = r_s6;

    // lane order: entry x, entry y, exit x, exit y
    always_comb begin
        n_s0.rej    = i_data.g.rej;
        n_s0.dotted = i_data.g.dotted;
        n_s0.nx     = i_data.g.nx;
        n_s0.ny     = i_data.g.ny;
        n_s0.sx     = i_data.g.sx;
        n_s0.sy     = i_data.g.sy;
        n_s0.prod[0] = PROD_W'(i_data.g.adx) * PROD_W'(i_data.t_in);
        n_s0.prod[1] = PROD_W'(i_data.g.ady) * PROD_W'(i_data.t_in);
        n_s0.prod[2] = PROD_W'(i_data.g.adx) * PROD_W'(i_data.t_out);
        n_s0.prod[3] = PROD_W'(i_data.g.ady) * PROD_W'(i_data.t_out);
    end

    always_comb begin
        logic [PROD_W-1:0] w_sum;
        n_s1.rej    = r_s0.rej;
        n_s1.dotted = r_s0.dotted;
        n_s1.nx     = r_s0.nx;
        n_s1.ny     = r_s0.ny;
        n_s1.sx     = r_s0.sx;
        n_s1.sy     = r_s0.sy;
        for (int i = 0; i < 4; i++) begin
            w_sum = r_s0.prod[i] + HALF_T;
            n_s1.rnd[i] = w_sum[PROD_W-1:TBITS];
        end
    end

    always_comb begin
        logic signed [V_W-1:0] w_base;
        logic signed [V_W-1:0] w_r;
        logic                  w_neg;
        n_s2.rej    = r_s1.rej;
        n_s2.dotted = r_s1.dotted;
        for (int i = 0; i < 4; i++) begin
            w_base = (i % 2 == 0) ? V_W'(r_s1.sx) : V_W'(r_s1.sy);
            w_neg  = (i % 2 == 0) ? r_s1.nx : r_s1.ny;
            w_r    = $signed(V_W'(r_s1.rnd[i]));
            n_s2.v[i] = w_neg ? w_base - w_r : w_base + w_r;
        end
    end

    // clamp into the bounds rectangle
    always_comb begin
        logic [CLP_W-1:0]      w_lo;
        logic [CLP_W-1:0]      w_hi;
        logic signed [V_W-1:0] w_v;
        n_s3.rej    = r_s2.rej;
        n_s3.dotted = r_s2.dotted;
        for (int i = 0; i < 4; i++) begin
            w_lo = (i % 2 == 0) ? {i_cfg.bound_left, {IN_FRAC{1'b0}}}
                                : {i_cfg.bound_top, {IN_FRAC{1'b0}}};
            w_hi = (i % 2 == 0) ? {i_cfg.bound_right, {IN_FRAC{1'b0}}}
                                : {i_cfg.bound_bottom, {IN_FRAC{1'b0}}};
            w_v  = $signed(r_s2.v[i]);
            if (w_v < $signed(V_W'(w_lo))) begin
                n_s3.c[i] = w_lo;
            end else if (w_v > $signed(V_W'(w_hi))) begin
                n_s3.c[i] = w_hi;
            end else begin
                n_s3.c[i] = w_v[CLP_W-1:0];
            end
        end
    end

    // pixel rounding and guard-precision deltas
    always_comb begin
        logic [CLP_W:0] w_sum;
        n_s4.rej    = r_s3.rej;
        n_s4.dotted = r_s3.dotted;
        for (int i = 0; i < 4; i++) begin
            w_sum = (CLP_W+1)'(r_s3.c[i]) + HALF_PX;
            n_s4.pix[i] = w_sum[IN_FRAC +: CFG_W];
        end
        for (int j = 0; j < 2; j++) begin
            n_s4.gd[j] = {1'b0, r_s3.c[j+2][CLP_W-1:IN_FRAC-GUARD]} -
                         {1'b0, r_s3.c[j][CLP_W-1:IN_FRAC-GUARD]};
        end
    end

    always_comb begin
        logic [GD_W-1:0] w_u;
        n_s5.rej    = r_s4.rej;
        n_s5.dotted = r_s4.dotted;
        n_s5.pix    = r_s4.pix;
        for (int j = 0; j < 2; j++) begin
            w_u = r_s4.gd[j][GD_W] ? GD_W'(-r_s4.gd[j]) : r_s4.gd[j][GD_W-1:0];
            n_s5.sq[j] = SQ_W'(w_u) * SQ_W'(w_u);
        end
    end

    // squared length, one pixel minimum, pre-scale for the count search
    always_comb begin
        logic [D2_W-1:0] w_d2;
        w_d2 = D2_W'(r_s5.sq[0]) + D2_W'(r_s5.sq[1]);
        n_s6.rej    = r_s5.rej | (w_d2[D2_W-1:DOT_SH] == '0);
        n_s6.dotted = r_s5.dotted;
        n_s6.pix    = r_s5.pix;
        n_s6.dsh    = r_s5.dotted ? DSH_W'(w_d2[D2_W-1:DOT_SH])
                                  : DSH_W'(w_d2[D2_W-1:SOLID_SH]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_s0 <= n_s0;
        if (w_en[1]) r_s1 <= n_s1;
        if (w_en[2]) r_s2 <= n_s2;
        if (w_en[3]) r_s3 <= n_s3;
        if (w_en[4]) r_s4 <= n_s4;
        if (w_en[5]) r_s5 <= n_s5;
        if (w_en[6]) r_s6 <= n_s6;
    end

endmodule

`default_nettype wire

// File: hw/rtl/lcd_count.sv
// bit-per-stage dot count search and result register
`timescale 1ns / 1ps
`default_nettype none

module lcd_count (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  lcd_pkg::t_span_out i_data,
    output logic               o_ready,
    lcd_res_if.source          o_res
);
    import lcd_pkg::*;

    localparam int NS = CNT_W + 1;

    typedef struct packed {
        logic                  rej;
        logic                  dotted;
        logic [3:0][CFG_W-1:0] pix;
        logic [DSH_W-1:0]      dsh;
        logic [CNT_W-1:0]      k;
    } t_cstage;

    typedef struct packed {
        logic                  visible;
        logic [3:0][CFG_W-1:0] pix;
        logic [CNT_W-1:0]      dot_count;
    } t_res;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;
    t_cstage       r_c [CNT_W];
    t_cstage       n_c [CNT_W];
    t_cstage       w_ld;
    t_res          r_out, n_out;

    // try one more count bit: keep it if (cand * step)^2 still fits the length
    function automatic t_cstage cnt_step(t_cstage s, logic [CNT_W-1:0] mask);
        t_cstage          o;
        logic [CNT_W-1:0] cand;
        logic [CSQ_W-1:0] sq;
        logic [KP_W-1:0]  kp;
        o    = s;
        cand = s.k | mask;
        sq   = CSQ_W'(cand) * CSQ_W'(cand);
        kp   = s.dotted ? KP_W'(sq) * KP_W'(DOT_K) : KP_W'(sq) * KP_W'(SOLID_K);
        if ((cand != MAX_CAND) && (kp <= KP_W'(s.dsh))) o.k = cand;
        return o;
    endfunction

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] | o_res.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] | w_en[k+1];
        end
    end

    assign o_ready = w_en[0];

    always_comb begin
        w_ld.rej    = i_data.rej;
        w_ld.dotted = i_data.dotted;
        w_ld.pix    = i_data.pix;
        w_ld.dsh    = i_data.dsh;
        w_ld.k      = '0;
        n_c[0] = cnt_step(w_ld, CNT_W'(1) << (CNT_W - 1));
        for (int k = 1; k < CNT_W; k++) begin
            n_c[k] = cnt_step(r_c[k-1], CNT_W'(1) << (CNT_W - 1 - k));
        end
    end

    // rejected segments report all zeros
    always_comb begin
        n_out.visible   = !r_c[CNT_W-1].rej;
        n_out.pix       = r_c[CNT_W-1].rej ? '0 : r_c[CNT_W-1].pix;
        n_out.dot_count = r_c[CNT_W-1].rej ? '0 : r_c[CNT_W-1].k + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CNT_W; k++) begin
            if (w_en[k]) r_c[k] <= n_c[k];
        end
        if (w_en[NS-1]) r_out <= n_out;
    end

    assign o_res.valid     = r_v[NS-1];
    assign o_res.visible   = r_out.visible;
    assign o_res.start_x   = r_out.pix[0];
    assign o_res.start_y   = r_out.pix[1];
    assign o_res.end_x     = r_out.pix[2];
    assign o_res.end_y     = r_out.pix[3];
    assign o_res.dot_count = r_out.dot_count;

    a_vis_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] && r_out.visible |-> r_out.dot_count != '0)
        else $error("visible beat with zero dot count");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] && !r_out.visible |-> r_out.pix == '0 && r_out.dot_count == '0)
        else $error("hidden beat with nonzero fields");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_v == '0)
        else $error("pipe not empty after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && !w_en[0] |=> r_v[0] && $stable(r_c[0].k))
        else $error("search stage lost data under stall");

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking bench for the line clip and dot count block
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import lcd_pkg::*;

    localparam int LATENCY   = 47;
    localparam int CYC_LIMIT = 400000;
    localparam int N_RANDOM  = 450;

    // one result beat as the block reports it
    typedef struct packed {
        logic        visible;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] end_x;
        logic [15:0] end_y;
        logic [12:0] dot_count;
    } t_clip_res;

    // one directed row: config tweak, segment, optional typed-in result
    typedef struct {
        logic        do_cfg;
        t_reg_idx    cfg_idx;
        logic [15:0] cfg_val;
        logic [23:0] fx;
        logic [23:0] fy;
        logic [23:0] tx;
        logic [23:0] ty;
        logic        dotted;
        logic        has_exp;
        t_clip_res   exp_res;
    } t_seg_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    lcd_seg_if seg_ch ();
    lcd_res_if res_ch ();

    line_clip_and_dot_count DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_seg      (seg_ch.sink),
        .o_res      (res_ch.source)
    );

    // shadow copy of the register file
    logic [15:0] shadow_cfg [8];

    t_clip_res   clip_expected [$];
    int unsigned n_fail;
    int unsigned n_cycles;
    logic        hold_off;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run-away guard
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYC_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // floor(n * 2^22 / m), with a flag for a nonzero remainder
    function automatic logic [63:0] t_quotient(input logic [63:0] n, input logic [63:0] m,
                                               output logic inexact);
        logic [63:0] r;
        logic [63:0] q;
        r = n;
        q = 0;
        for (int i = 0; i < TBITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= m) begin
                r = r - m;
                q[0] = 1'b1;
            end
        end
        inexact = (r != 0);
        return q;
    endfunction

    // point at parameter t along the direction, product rounded to nearest
    function automatic longint point_at(input longint s, input longint d, input longint t);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        r = (mag * 64'(t) + (64'd1 << (TBITS - 1))) >> TBITS;
        return (d < 0) ? s - longint'(r) : s + longint'(r);
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [15:0] to_pixel(input longint v);
        logic [63:0] u;
        u = (64'(v) + (64'd1 << (IN_FRAC - 1))) >> IN_FRAC;
        return u[15:0];
    endfunction

    // expected clip result of one segment under the shadow registers
    function automatic t_clip_res clip_segment(input logic [23:0] fx_r, input logic [23:0] fy_r,
                                               input logic [23:0] tx_r, input logic [23:0] ty_r,
                                               input logic dotted);
        t_clip_res res;
        longint fx, fy, tx, ty, sx, sy, dx, dy, bl, bt, br, bb;
        longint p [4];
        longint q [4];
        longint n, m, t_first, t_last, ax, ay, ex, ey, gx, gy;
        logic [63:0] tq, d2, one_px, spacing, lo, hi, mid, len;
        logic inexact, reject;
        res = '{default: '0};
        fx = longint'(signed'(fx_r));
        fy = longint'(signed'(fy_r));
        tx = longint'(signed'(tx_r));
        ty = longint'(signed'(ty_r));
        sx = (longint'(shadow_cfg[REG_AREA_LEFT]) <<< IN_FRAC)
             + fx * longint'(shadow_cfg[REG_AREA_WIDTH]);
        sy = (longint'(shadow_cfg[REG_AREA_TOP]) <<< IN_FRAC)
             + fy * longint'(shadow_cfg[REG_AREA_HEIGHT]);
        dx = (tx - fx) * longint'(shadow_cfg[REG_AREA_WIDTH]);
        dy = (ty - fy) * longint'(shadow_cfg[REG_AREA_HEIGHT]);
        bl = longint'(shadow_cfg[REG_BOUND_LEFT]) <<< IN_FRAC;
        bt = longint'(shadow_cfg[REG_BOUND_TOP]) <<< IN_FRAC;
        br = longint'(shadow_cfg[REG_BOUND_RIGHT]) <<< IN_FRAC;
        bb = longint'(shadow_cfg[REG_BOUND_BOTTOM]) <<< IN_FRAC;
        if (br <= bl || bb <= bt)
            return res;
        p[0] = -dx; p[1] = dx; p[2] = -dy; p[3] = dy;
        q[0] = sx - bl; q[1] = br - sx; q[2] = sy - bt; q[3] = bb - sy;
        t_first = 0;
        t_last  = longint'(1) << TBITS;
        reject  = 1'b0;
        for (int e = 0; e < 4 && !reject; e++) begin
            if (p[e] == 0) begin
                if (q[e] < 0) reject = 1'b1;
            end else if (p[e] < 0) begin
                n = -q[e];
                m = -p[e];
                if (n > m) begin
                    reject = 1'b1;
                end else if (n > 0) begin
                    // entry rounds up
                    if (n == m) begin
                        tq = 64'd1 << TBITS;
                    end else begin
                        tq = t_quotient(64'(n), 64'(m), inexact);
                        if (inexact) tq = tq + 1;
                    end
                    if (longint'(tq) > t_first) t_first = longint'(tq);
                end
            end else begin
                n = q[e];
                m = p[e];
                if (n < 0) begin
                    reject = 1'b1;
                end else if (n < m) begin
                    // exit rounds down
                    tq = t_quotient(64'(n), 64'(m), inexact);
                    if (longint'(tq) < t_last) t_last = longint'(tq);
                end
            end
            if (t_first > t_last) reject = 1'b1;
        end
        if (reject)
            return res;
        ax = clamp_to(point_at(sx, dx, t_first), bl, br);
        ay = clamp_to(point_at(sy, dy, t_first), bt, bb);
        ex = clamp_to(point_at(sx, dx, t_last), bl, br);
        ey = clamp_to(point_at(sy, dy, t_last), bt, bb);
        gx = (ex >>> (IN_FRAC - GUARD)) - (ax >>> (IN_FRAC - GUARD));
        gy = (ey >>> (IN_FRAC - GUARD)) - (ay >>> (IN_FRAC - GUARD));
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        d2 = 64'(gx) * 64'(gx) + 64'(gy) * 64'(gy);
        one_px = 64'd1 << (PIX_FRAC + GUARD);
        spacing = dotted ? (64'd5 << (PIX_FRAC + GUARD)) : (64'd3 << (PIX_FRAC + GUARD - 2));
        if (d2 < one_px * one_px)
            return res;
        // largest count whose length squared still fits
        lo = 0;
        hi = 8190;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            len = mid * spacing;
            if (len * len <= d2) lo = mid;
            else hi = mid - 1;
        end
        res.visible   = 1'b1;
        res.start_x   = to_pixel(ax);
        res.start_y   = to_pixel(ay);
        res.end_x     = to_pixel(ex);
        res.end_y     = to_pixel(ey);
        res.dot_count = 13'(lo + 1);
        return res;
    endfunction

    // the two config writes happen only while the pipe is empty
    // write enable stays up for back-to-back writes; the caller drops it
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        shadow_cfg[idx] = val;
    endtask

    task automatic drain_pipe();
        while (clip_expected.size() != 0) @(posedge i_clk);
        // no segment is dropped, but let the tail settle anyway
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // offer one segment and wait until it is accepted; a random gap may come first
    task automatic send_segment(input logic [23:0] fx, input logic [23:0] fy,
                                input logic [23:0] tx, input logic [23:0] ty,
                                input logic dotted, input logic has_exp,
                                input t_clip_res exp_res, input int gap);
        t_clip_res pred;
        t_clip_res want_res;
        if (gap > 0) begin
            seg_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        seg_ch.valid  <= 1'b1;
        seg_ch.from_x <= fx;
        seg_ch.from_y <= fy;
        seg_ch.to_x   <= tx;
        seg_ch.to_y   <= ty;
        seg_ch.dotted <= dotted;
        @(posedge i_clk);
        while (!seg_ch.ready) @(posedge i_clk);
        pred = clip_segment(fx, fy, tx, ty, dotted);
        if (has_exp && pred != exp_res)
            $error("typed-in result disagrees with the predictor for a directed row");
        want_res = has_exp ? exp_res : pred;
        clip_expected = {clip_expected, want_res};
    endtask

    task automatic close_burst();
        seg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_off) begin
            res_ch.ready <= 1'b0;
        end else begin
            case (n_cycles[6:5])
                2'd0:    res_ch.ready <= 1'b1;
                2'd1:    res_ch.ready <= ($urandom_range(0, 3) != 0);
                2'd2:    res_ch.ready <= ($urandom_range(0, 1) != 0);
                default: res_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_clip_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (clip_expected.size() == 0) begin
                $error("result beat with nothing expected");
                n_fail++;
            end else begin
                want = clip_expected.pop_front();
                if (res_ch.visible !== want.visible) begin
                    $error("visible exp %0d got %0d", want.visible, res_ch.visible);
                    n_fail++;
                end
                if (res_ch.start_x !== want.start_x) begin
                    $error("start_x exp %0d got %0d", want.start_x, res_ch.start_x);
                    n_fail++;
                end
                if (res_ch.start_y !== want.start_y) begin
                    $error("start_y exp %0d got %0d", want.start_y, res_ch.start_y);
                    n_fail++;
                end
                if (res_ch.end_x !== want.end_x) begin
                    $error("end_x exp %0d got %0d", want.end_x, res_ch.end_x);
                    n_fail++;
                end
                if (res_ch.end_y !== want.end_y) begin
                    $error("end_y exp %0d got %0d", want.end_y, res_ch.end_y);
                    n_fail++;
                end
                if (res_ch.dot_count !== want.dot_count) begin
                    $error("dot_count exp %0d got %0d", want.dot_count, res_ch.dot_count);
                    n_fail++;
                end
            end
        end
    end

    // fraction in Q8.16, mostly within the area with some margin outside
    function automatic logic [23:0] rand_frac();
        case ($urandom_range(0, 9))
            0:       return 24'($urandom);
            1:       return 24'($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000);
            2:       return 24'(int'($urandom_range(0, 196608)) - 65536);
            default: return 24'($urandom_range(0, 65536));
        endcase
    endfunction

    // pick one of a few register settings, extremes included
    task automatic load_setting(input int which);
        logic [15:0] vals [8];
        case (which)
            0: vals = '{16'd0, 16'd0, 16'd2048, 16'd2048, 16'd0, 16'd0, 16'd2048, 16'd2048};
            1: vals = '{16'd160, 16'd320, 16'd8000, 16'd4000,
                        16'd400, 16'd500, 16'd6000, 16'd3800};
            2: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
            3: vals = '{16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd16, 16'd16};
            default: begin
                for (int k = 0; k < 4; k++) vals[k] = 16'($urandom_range(0, 8000));
                vals[2] = 16'($urandom_range(1, 30000));
                vals[3] = 16'($urandom_range(1, 30000));
                vals[4] = 16'($urandom_range(0, 20000));
                vals[5] = 16'($urandom_range(0, 20000));
                vals[6] = vals[4] + 16'($urandom_range(1, 20000));
                vals[7] = vals[5] + 16'($urandom_range(1, 20000));
            end
        endcase
        for (int k = 0; k < 8; k++) write_reg(t_reg_idx'(k), vals[k]);
        i_cfg_we <= 1'b0;
    endtask

    t_seg_row  seg_table [$];
    t_clip_res blank;

    initial begin
        t_seg_row row;
        int       burst;
        int       sent;
        n_fail       = 0;
        n_cycles     = 0;
        hold_off     = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        seg_ch.valid = 1'b0;
        seg_ch.from_x = '0;
        seg_ch.from_y = '0;
        seg_ch.to_x   = '0;
        seg_ch.to_y   = '0;
        seg_ch.dotted = 1'b0;
        blank = '{default: '0};
        shadow_cfg = '{16'd0, 16'd0, 16'd2048, 16'd2048, 16'd0, 16'd0, 16'd2048, 16'd2048};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: reset registers, then special cases
        row = '{cfg_idx: REG_AREA_LEFT, default: '0};
        // full diagonal across the area, solid: 128 px * sqrt2 / 0.75 -> 241 gaps, 242 dots
        row.fx = 24'd0; row.fy = 24'd0; row.tx = 24'h010000; row.ty = 24'h010000;
        row.has_exp = 1'b1;
        row.exp_res = '{1'b1, 16'd0, 16'd0, 16'd2048, 16'd2048, 13'd242};
        seg_table = {seg_table, row};
        // same but dotted
        row.dotted = 1'b1;
        row.has_exp = 1'b0;
        seg_table = {seg_table, row};
        // point segment
        row = '{cfg_idx: REG_AREA_LEFT, default: '0};
        row.fx = 24'h008000; row.fy = 24'h008000; row.tx = 24'h008000; row.ty = 24'h008000;
        row.has_exp = 1'b1; row.exp_res = blank;
        seg_table = {seg_table, row};
        // parallel edge outside the bounds
        row.fx = 24'h800000; row.fy = 24'h008000; row.tx = 24'h800000; row.ty = 24'hFFF000;
        seg_table = {seg_table, row};
        // entirely to the right
        row.fx = 24'h7FFFFF; row.fy = 24'd0; row.tx = 24'h020000; row.ty = 24'h010000;
        seg_table = {seg_table, row};
        // field extremes crossing the whole area
        row = '{cfg_idx: REG_AREA_LEFT, default: '0};
        row.fx = 24'h800000; row.fy = 24'h800000; row.tx = 24'h7FFFFF; row.ty = 24'h7FFFFF;
        row.dotted = 1'b1;
        seg_table = {seg_table, row};
        row.fy = 24'h7FFFFF; row.ty = 24'h800000; row.dotted = 1'b0;
        seg_table = {seg_table, row};
        // horizontal and vertical short pieces
        row.fx = 24'h001000; row.fy = 24'h004000; row.tx = 24'h003000; row.ty = 24'h004000;
        seg_table = {seg_table, row};
        row.fx = 24'h004000; row.fy = 24'h00F000; row.tx = 24'h004000; row.ty = 24'h00E000;
        seg_table = {seg_table, row};
        // just under and just over one pixel
        row.fx = 24'd0; row.fy = 24'd0; row.tx = 24'd511; row.ty = 24'd0;
        seg_table = {seg_table, row};
        row.tx = 24'd513;
        seg_table = {seg_table, row};
        // empty bounds: right not past left
        row = '{cfg_idx: REG_AREA_LEFT, default: '0};
        row.do_cfg = 1'b1; row.cfg_idx = REG_BOUND_RIGHT; row.cfg_val = 16'd0;
        row.fx = 24'd0; row.fy = 24'd0; row.tx = 24'h010000; row.ty = 24'h010000;
        row.has_exp = 1'b1; row.exp_res = blank;
        seg_table = {seg_table, row};
        row.cfg_val = 16'd2048;
        row.has_exp = 1'b0;
        seg_table = {seg_table, row};
        // empty bounds: bottom equal to top
        row.cfg_idx = REG_BOUND_BOTTOM; row.cfg_val = 16'd0;
        row.has_exp = 1'b1;
        seg_table = {seg_table, row};
        row.cfg_val = 16'd2048; row.has_exp = 1'b0;
        seg_table = {seg_table, row};
        // zero area size collapses to a point
        row.cfg_idx = REG_AREA_WIDTH; row.cfg_val = 16'd0;
        row.ty = 24'd0;
        row.has_exp = 1'b1;
        seg_table = {seg_table, row};
        row.cfg_val = 16'd2048; row.has_exp = 1'b0;
        seg_table = {seg_table, row};
        // long segment, dot count far up its range
        row.cfg_idx = REG_AREA_WIDTH; row.cfg_val = 16'hFFFF;
        row.do_cfg = 1'b1;
        row.fx = 24'd0; row.tx = 24'h010000;
        seg_table = {seg_table, row};
        row.cfg_idx = REG_BOUND_RIGHT; row.cfg_val = 16'hFFFF;
        seg_table = {seg_table, row};

        foreach (seg_table[r]) begin
            if (seg_table[r].do_cfg) begin
                drain_pipe();
                write_reg(seg_table[r].cfg_idx, seg_table[r].cfg_val);
                i_cfg_we <= 1'b0;
            end
            send_segment(seg_table[r].fx, seg_table[r].fy, seg_table[r].tx, seg_table[r].ty,
                         seg_table[r].dotted, seg_table[r].has_exp, seg_table[r].exp_res,
                         $urandom_range(0, 2));
            close_burst();
        end

        // random part in phases of register settings
        sent = 0;
        for (int phase = 0; phase < 9; phase++) begin
            drain_pipe();
            load_setting(phase < 4 ? phase : 4);
            if (phase == 1) begin
                // hold the result side off long enough to back up the pipe
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            while (sent < (phase + 1) * N_RANDOM / 9) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++) begin
                    send_segment(rand_frac(), rand_frac(), rand_frac(), rand_frac(),
                                 1'($urandom), 1'b0, blank,
                                 (b == 0) ? $urandom_range(0, 8) : 0);
                    sent++;
                end
                close_burst();
            end
        end

        drain_pipe();
        if (n_fail == 0 && clip_expected.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/lcd_pkg.sv
hw/rtl/lcd_if.sv
hw/rtl/lcd_map.sv
hw/rtl/lcd_clip.sv
hw/rtl/lcd_span.sv
hw/rtl/lcd_count.sv
hw/rtl/line_clip_and_dot_count.sv
tb/tb.sv
